// ===== sv/kosis_pkg.sv =====
// shared types and constants for the top-k smallest index sorter
`timescale 1ns / 1ps

package kosis_pkg;

  // fixed field widths
  localparam int VALUE_W = 32;
  localparam int POS_W   = 16;
  localparam int CFG_W   = 5;

  // parameter defaults and register reset value
  localparam int MAX_KEEP_DEF   = 16;
  localparam int MAX_ITEMS_DEF  = 65536;
  localparam int KEEP_COUNT_RST = 16;

  // input beat payload
  typedef struct packed {
    logic signed [VALUE_W-1:0] sample_value;
    logic                      is_last;
  } in_t;

  // output beat payload
  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             final_result;
  } out_t;

  // contents of one sorting cell
  typedef struct packed {
    logic                      occ;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          pos;
  } cell_data_t;

  // commands broadcast to every cell
  typedef struct packed {
    logic insert;
    logic drain;
    logic clear;
  } cell_ctrl_t;

endpackage

// ===== sv/kosis_cell.sv =====
// one compare-and-shift cell of the sorted insertion chain
`timescale 1ns / 1ps

module kosis_cell (
  input  logic                                clk,
  input  logic                                rst,
  input  kosis_pkg::cell_ctrl_t               ctrl,
  input  logic signed [kosis_pkg::VALUE_W-1:0] new_value,
  input  logic [kosis_pkg::POS_W-1:0]         new_pos,
  input  kosis_pkg::cell_data_t               prev_data,
  input  logic                                prev_gt,
  input  kosis_pkg::cell_data_t               next_data,
  output kosis_pkg::cell_data_t               data,
  output logic                                gt
);

  kosis_pkg::cell_data_t data_next;

  // new sample belongs at or before this cell (equal values go behind)
  assign gt = !data.occ || (new_value < data.value);

  // insert: take new sample or the left neighbor; drain: take the right neighbor
  always_comb begin
    data_next = data;
    if (ctrl.insert) begin
      if (gt) begin
        if (prev_gt) begin
          data_next = prev_data;
        end else begin
          data_next.occ   = 1'b1;
          data_next.value = new_value;
          data_next.pos   = new_pos;
        end
      end
    end else if (ctrl.drain) begin
      data_next = next_data;
    end
  end

  // occupancy flag and payload
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      data.occ <= 1'b0;
    end else begin
      data.occ <= data_next.occ;
    end
    data.value <= data_next.value;
    data.pos   <= data_next.pos;
  end

endmodule

// ===== sv/k_smallest_ordered_index_sort_core.sv =====
// top level of the streaming top-k smallest index sorter
`timescale 1ns / 1ps
// Usage:
//   in channel (in_valid/in_ready/in_data) carries one signed Q16.16 sample a
//   beat; samples are numbered by arrival from 0. A chain of MAX_KEEP compare
//   cells keeps the smallest samples sorted, equal values behind older ones.
//   One sample is taken every cycle while no result list is being sent.
//   cfg channel (cfg_valid/cfg_ready/cfg_data) writes keep_count; cfg_ready is
//   always high. Zero acts as 1, values above MAX_KEEP act as MAX_KEEP.
//   On a beat with is_last set, the block sends min(keep_count, kept) positions
//   on the out channel in ascending order of value, the last one flagged with
//   final_result. Once the last sample is accepted the sequencer enters its
//   drain state and loads the first position into the output register when
//   that register is free; the chain shifts one cell toward the head per
//   delivered position. The in channel is held off until the last position
//   sits in the output register. A stalled receiver simply holds the output
//   register and the chain. Reset empties the chain, zeroes the arrival count,
//   sets keep_count to 16 and drops any pending output; no clearing pass is
//   needed.

module k_smallest_ordered_index_sort_core #(
  parameter int MAX_KEEP  = kosis_pkg::MAX_KEEP_DEF,
  parameter int MAX_ITEMS = kosis_pkg::MAX_ITEMS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  kosis_pkg::in_t              in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output kosis_pkg::out_t             out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [kosis_pkg::CFG_W-1:0] cfg_data
);

  localparam int CNT_W = $clog2(MAX_KEEP + 1);
  localparam int ARR_W = $clog2(MAX_ITEMS);
  localparam int CMP_W = (CNT_W > kosis_pkg::CFG_W) ? CNT_W : kosis_pkg::CFG_W;

  typedef enum logic {
    ST_COLLECT,
    ST_DRAIN
  } state_t;

  state_t                        state;
  logic [kosis_pkg::CFG_W-1:0]   keep_count;
  logic [ARR_W-1:0]              arrival_count;
  logic [CNT_W-1:0]              kept_fill;
  logic [CNT_W-1:0]              drain_left;

  logic                          in_fire;
  logic                          out_load;
  logic [CNT_W-1:0]              fill_after;
  logic [CMP_W-1:0]              want;
  logic [CMP_W-1:0]              fill_ext;
  logic [CNT_W-1:0]              emit_count;
  logic                          last_emit;

  kosis_pkg::cell_ctrl_t         ctrl;
  kosis_pkg::cell_data_t         cell_q [MAX_KEEP];
  logic                          cell_gt [MAX_KEEP];

  assign in_ready  = (state == ST_COLLECT);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign out_load  = (state == ST_DRAIN) && (!out_valid || out_ready);
  assign last_emit = (drain_left == CNT_W'(1));

  // fill level after this sample goes in
  assign fill_after = (kept_fill == CNT_W'(MAX_KEEP)) ? kept_fill : kept_fill + 1'b1;

  // clamp keep_count to 1..MAX_KEEP, then limit to the kept entries
  always_comb begin
    want = CMP_W'(keep_count);
    if (want == '0) begin
      want = CMP_W'(1);
    end else if (want > CMP_W'(MAX_KEEP)) begin
      want = CMP_W'(MAX_KEEP);
    end
    fill_ext   = CMP_W'(fill_after);
    emit_count = (fill_ext < want) ? fill_after : CNT_W'(want);
  end

  // commands to the chain
  assign ctrl.insert = in_fire;
  assign ctrl.drain  = out_load && !last_emit;
  assign ctrl.clear  = out_load && last_emit;

  // the sorting chain
  for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
    kosis_pkg::cell_data_t prev_d;
    kosis_pkg::cell_data_t next_d;
    logic                  prev_g;

    if (i == 0) begin : g_head
      assign prev_d = '0;
      assign prev_g = 1'b0;
    end else begin : g_body
      assign prev_d = cell_q[i-1];
      assign prev_g = cell_gt[i-1];
    end

    if (i == MAX_KEEP - 1) begin : g_tail
      assign next_d = '0;
    end else begin : g_mid
      assign next_d = cell_q[i+1];
    end

    kosis_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .new_value (in_data.sample_value),
      .new_pos   (kosis_pkg::POS_W'(arrival_count)),
      .prev_data (prev_d),
      .prev_gt   (prev_g),
      .next_data (next_d),
      .data      (cell_q[i]),
      .gt        (cell_gt[i])
    );
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      keep_count <= kosis_pkg::CFG_W'(kosis_pkg::KEEP_COUNT_RST);
    end else if (cfg_valid && cfg_ready) begin
      keep_count <= cfg_data;
    end
  end

  // sequencer: collect samples, then send the sorted head positions
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_COLLECT;
      arrival_count <= '0;
      kept_fill     <= '0;
      drain_left    <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && out_ready && !out_load) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_COLLECT: begin
          if (in_fire) begin
            if (in_data.is_last) begin
              arrival_count <= '0;
              kept_fill     <= '0;
              drain_left    <= emit_count;
              state         <= ST_DRAIN;
            end else begin
              kept_fill <= fill_after;
              if (arrival_count == ARR_W'(MAX_ITEMS - 1)) begin
                arrival_count <= '0;
              end else begin
                arrival_count <= arrival_count + 1'b1;
              end
            end
          end
        end
        ST_DRAIN: begin
          if (out_load) begin
            out_valid <= 1'b1;
            drain_left <= drain_left - 1'b1;
            if (last_emit) begin
              state <= ST_COLLECT;
            end
          end
        end
        default: begin
          state <= ST_COLLECT;
        end
      endcase
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.position     <= cell_q[0].pos;
      out_data.final_result <= last_emit;
    end
  end

endmodule

// ===== sv/kosis_checker.sv =====
// port-level checks for the top-k smallest index sorter, bound to the top level
`timescale 1ns / 1ps

module kosis_checker (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_ready,
  input kosis_pkg::in_t  in_data,
  input logic            out_valid,
  input logic            out_ready,
  input kosis_pkg::out_t out_data
);

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  // a last sample always starts a result list
  a_last_drains: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.is_last |=> !in_ready ##1 out_valid)
    else $error("no result list after last sample");

  // input stays closed while the list is incomplete
  a_no_input_mid_list: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.final_result |-> !in_ready)
    else $error("input open before list complete");

  // reset leaves the block empty and open
  a_reset_state: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("bad state after reset");

endmodule

bind k_smallest_ordered_index_sort_core kosis_checker u_kosis_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
